/* sv/mts_pkg.sv */
// Shared types and constants for the masked table select block.
package mts_pkg;

	// Fixed field widths of the item channels
	localparam int MODE_W  = 2;
	localparam int IDX_W   = 6;
	localparam int FLAG_W  = 16;
	localparam int ROLE_W  = 8;
	localparam int SIDE_W  = 3;
	localparam int RAND_W  = 16;
	localparam int CNT_W   = 7;
	localparam int SIDES   = 8;

	// Remainder register for (index + 1) mod count, and its top shift
	localparam int REM_W   = IDX_W + 1;
	localparam logic [2:0] REM_TOP = 3'(IDX_W);

	// Configuration register file
	localparam int APB_AW  = 3;
	localparam int APB_DW  = 32;
	localparam logic REG_ENTRY_COUNT = 1'b0;
	localparam logic [CNT_W-1:0] ENTRY_COUNT_RST = 7'd14;

	// Item operation codes
	typedef enum logic [MODE_W-1:0] {
		MODE_WRITE  = 2'd0,
		MODE_RANDOM = 2'd1,
		MODE_NEXT   = 2'd2,
		MODE_NOP    = 2'd3
	} mode_t;

endpackage

/* sv/mts_in_if.sv */
// Input item channel: valid/ready handshake with the query or write payload.
interface mts_in_if;
	logic                        valid;
	logic                        ready;
	logic [mts_pkg::MODE_W-1:0]  mode;
	logic [mts_pkg::IDX_W-1:0]   entry_index;
	logic [mts_pkg::FLAG_W-1:0]  entry_flags;
	logic [mts_pkg::ROLE_W-1:0]  role_mask;
	logic [mts_pkg::SIDE_W-1:0]  side;
	logic                        side_given;
	logic [mts_pkg::RAND_W-1:0]  random_word;

	modport source (
		output valid, mode, entry_index, entry_flags, role_mask, side, side_given,
			random_word,
		input  ready
	);
	modport sink (
		input  valid, mode, entry_index, entry_flags, role_mask, side, side_given,
			random_word,
		output ready
	);
endinterface

/* sv/mts_out_if.sv */
// Result channel: valid/ready handshake with the selected entry.
interface mts_out_if;
	logic                       valid;
	logic                       ready;
	logic [mts_pkg::IDX_W-1:0]  chosen_entry;
	logic                       found;

	modport source (output valid, chosen_entry, found, input ready);
	modport sink   (input valid, chosen_entry, found, output ready);
endinterface

/* sv/mts_cfg.sv */
// APB-style configuration register holding the entry count.
module mts_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [mts_pkg::APB_AW-1:0]   paddr,
	input  logic [mts_pkg::APB_DW-1:0]   pwdata,
	output logic [mts_pkg::APB_DW-1:0]   prdata,
	output logic                         pready,
	output logic [mts_pkg::CNT_W-1:0]    entry_count
);

	logic [mts_pkg::CNT_W-1:0] entry_count_q;
	logic                      hit_reg;

	// Register index is the word address
	assign hit_reg = (paddr[2] == mts_pkg::REG_ENTRY_COUNT);
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= mts_pkg::ENTRY_COUNT_RST;
		end else if (psel && penable && pwrite && hit_reg) begin
			entry_count_q <= pwdata[mts_pkg::CNT_W-1:0];
		end
	end

	// Read-back
	always_comb begin
		prdata = '0;
		if (hit_reg) begin
			prdata = mts_pkg::APB_DW'(entry_count_q);
		end
	end

	assign entry_count = entry_count_q;

endmodule

/* sv/mts_table.sv */
// Flag table: one write port, one registered read port, valid bit per entry.
module mts_table #(
	parameter int MAX_ENTRIES = 64
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           wr_en,
	input  logic [$clog2(MAX_ENTRIES)-1:0] wr_addr,
	input  logic [mts_pkg::FLAG_W-1:0]     wr_data,
	input  logic [$clog2(MAX_ENTRIES)-1:0] rd_addr,
	output logic [mts_pkg::FLAG_W-1:0]     rd_data
);

	logic [mts_pkg::FLAG_W-1:0] mem [MAX_ENTRIES];
	logic [MAX_ENTRIES-1:0]     valid_q;
	logic [mts_pkg::FLAG_W-1:0] rdata_q;
	logic                       rvalid_q;

	// Storage array
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_q <= mem[rd_addr];
	end

	// Entries never written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (wr_en) begin
				valid_q[wr_addr] <= 1'b1;
			end
			rvalid_q <= valid_q[rd_addr];
		end
	end

	assign rd_data = rvalid_q ? rdata_q : '0;

endmodule

/* sv/mts_seq.sv */
// Query sequencer: start reduction, table walk with shared match test, pick.
module mts_seq #(
	parameter int MAX_ENTRIES = 64,
	parameter int ROLE_BITS   = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	mts_in_if.sink                         in_ch,
	mts_out_if.source                      out_ch,
	input  logic [mts_pkg::CNT_W-1:0]      entry_count,
	output logic                           wr_en,
	output logic [$clog2(MAX_ENTRIES)-1:0] wr_addr,
	output logic [mts_pkg::FLAG_W-1:0]     wr_data,
	output logic [$clog2(MAX_ENTRIES)-1:0] rd_addr,
	input  logic [mts_pkg::FLAG_W-1:0]     rd_data
);

	localparam int AW  = $clog2(MAX_ENTRIES);
	localparam int CW  = $clog2(MAX_ENTRIES + 1);
	localparam int MW  = ROLE_BITS + mts_pkg::SIDES;
	localparam int RL  = (ROLE_BITS < mts_pkg::ROLE_W) ? ROLE_BITS : mts_pkg::ROLE_W;
	localparam int FL  = (MW < mts_pkg::FLAG_W) ? MW : mts_pkg::FLAG_W;
	localparam int IW  = mts_pkg::IDX_W;
	localparam int RW  = mts_pkg::REM_W;
	localparam int PW  = mts_pkg::RAND_W + CW;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MOD,
		ST_SCAN,
		ST_MUL,
		ST_LIST,
		ST_LIST_WAIT,
		ST_DONE
	} state_t;

	state_t          state_q;
	mts_pkg::mode_t  mode_q;
	logic [MW-1:0]   mask_q;
	logic [mts_pkg::RAND_W-1:0] rand_q;
	logic [CW-1:0]   count_q;
	logic [RW-1:0]   rem_q;
	logic [2:0]      shift_q;
	logic [AW-1:0]   addr_q;
	logic [CW-1:0]   iss_q;
	logic            pend_s1;
	logic [AW-1:0]   addr_s1;
	logic [CW-1:0]   matches_q;
	logic [AW-1:0]   ordinal_q;
	logic [AW-1:0]   res_pos_q;
	logic            res_found_q;
	logic            out_valid_q;
	logic [IW-1:0]   out_chosen_q;
	logic            out_found_q;

	// Match list for random picks
	logic [AW-1:0]   list_mem [MAX_ENTRIES];
	logic [AW-1:0]   list_rdata_q;

	logic            accept;
	mts_pkg::mode_t  mode_in;
	logic [MW-1:0]   mask_d;
	logic [CW-1:0]   count_d;
	logic [MW-1:0]   flag_ext;
	logic            hit;
	logic            list_we;
	logic [AW-1:0]   addr_nx;
	logic [15:0]     sub_val;
	logic [RW-1:0]   rem_nx;
	logic [PW-1:0]   prod;

	assign accept  = in_ch.valid && in_ch.ready;
	assign mode_in = mts_pkg::mode_t'(in_ch.mode);
	assign in_ch.ready = (state_q == ST_IDLE);

	// Table writes go straight through on acceptance
	assign wr_en   = accept && (mode_in == mts_pkg::MODE_WRITE)
		&& (32'(in_ch.entry_index) < MAX_ENTRIES);
	assign wr_addr = AW'(in_ch.entry_index);
	assign wr_data = in_ch.entry_flags;
	assign rd_addr = addr_q;

	// Match mask: role bits, then one side bit when a side is given
	always_comb begin
		mask_d = '0;
		for (int b = 0; b < RL; b++) begin
			mask_d[b] = in_ch.role_mask[b];
		end
		for (int j = 0; j < mts_pkg::SIDES; j++) begin
			mask_d[ROLE_BITS + j] = in_ch.side_given && (in_ch.side == 3'(j));
		end
	end

	// Entries in use, saturated to the table depth
	assign count_d = (32'(entry_count) > MAX_ENTRIES) ? CW'(MAX_ENTRIES) : CW'(entry_count);

	// Shared match test on the returning table word
	always_comb begin
		flag_ext = '0;
		for (int b = 0; b < FL; b++) begin
			flag_ext[b] = rd_data[b];
		end
	end
	assign hit = ((flag_ext & mask_q) == mask_q);

	// Walk address with wrap at the entry count
	assign addr_nx = ((CW'(addr_q) + CW'(1)) == count_q) ? '0 : addr_q + AW'(1);

	// One restoring step of the start reduction
	always_comb begin
		sub_val = 16'(count_q) << shift_q;
		rem_nx  = rem_q;
		if (16'(rem_q) >= sub_val) begin
			rem_nx = rem_q - RW'(sub_val);
		end
	end

	assign prod    = PW'(rand_q) * PW'(matches_q);
	assign list_we = (state_q == ST_SCAN) && pend_s1 && hit
		&& (mode_q == mts_pkg::MODE_RANDOM);

	// Match list storage
	always_ff @(posedge clk) begin
		if (list_we) begin
			list_mem[matches_q[AW-1:0]] <= addr_s1;
		end
		list_rdata_q <= list_mem[ordinal_q];
	end

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			mode_q       <= mts_pkg::MODE_NOP;
			mask_q       <= '0;
			rand_q       <= '0;
			count_q      <= '0;
			rem_q        <= '0;
			shift_q      <= '0;
			addr_q       <= '0;
			iss_q        <= '0;
			pend_s1      <= 1'b0;
			addr_s1      <= '0;
			matches_q    <= '0;
			ordinal_q    <= '0;
			res_pos_q    <= '0;
			res_found_q  <= 1'b0;
			out_valid_q  <= 1'b0;
			out_chosen_q <= '0;
			out_found_q  <= 1'b0;
		end else begin
			// ST_DONE reloads the result register itself
			if (out_ch.ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						mode_q      <= mode_in;
						mask_q      <= mask_d;
						rand_q      <= in_ch.random_word;
						count_q     <= count_d;
						res_pos_q   <= '0;
						res_found_q <= 1'b0;
						addr_q      <= '0;
						iss_q       <= '0;
						pend_s1     <= 1'b0;
						matches_q   <= '0;
						rem_q       <= RW'(in_ch.entry_index) + RW'(1);
						shift_q     <= mts_pkg::REM_TOP;
						case (mode_in)
							mts_pkg::MODE_RANDOM: begin
								state_q <= (count_d == '0) ? ST_DONE : ST_SCAN;
							end
							mts_pkg::MODE_NEXT: begin
								state_q <= (count_d == '0) ? ST_DONE : ST_MOD;
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end
				ST_MOD: begin
					rem_q <= rem_nx;
					if (shift_q == '0) begin
						addr_q  <= AW'(rem_nx);
						state_q <= ST_SCAN;
					end else begin
						shift_q <= shift_q - 3'd1;
					end
				end
				ST_SCAN: begin
					if (pend_s1 && hit && (mode_q == mts_pkg::MODE_NEXT)) begin
						res_pos_q   <= addr_s1;
						res_found_q <= 1'b1;
						pend_s1     <= 1'b0;
						state_q     <= ST_DONE;
					end else begin
						if (pend_s1 && hit) begin
							matches_q <= matches_q + CW'(1);
						end
						if (iss_q != count_q) begin
							pend_s1 <= 1'b1;
							addr_s1 <= addr_q;
							addr_q  <= addr_nx;
							iss_q   <= iss_q + CW'(1);
						end else begin
							pend_s1 <= 1'b0;
							if (!pend_s1) begin
								if ((mode_q == mts_pkg::MODE_RANDOM) && (matches_q != '0)) begin
									state_q <= ST_MUL;
								end else begin
									state_q <= ST_DONE;
								end
							end
						end
					end
				end
				ST_MUL: begin
					ordinal_q <= AW'(prod[PW-1:mts_pkg::RAND_W]);
					state_q   <= ST_LIST;
				end
				ST_LIST: begin
					state_q <= ST_LIST_WAIT;
				end
				ST_LIST_WAIT: begin
					res_pos_q   <= list_rdata_q;
					res_found_q <= 1'b1;
					state_q     <= ST_DONE;
				end
				ST_DONE: begin
					if (!out_valid_q || out_ch.ready) begin
						out_valid_q  <= 1'b1;
						out_chosen_q <= IW'(res_pos_q);
						out_found_q  <= res_found_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.chosen_entry = out_chosen_q;
	assign out_ch.found        = out_found_q;

endmodule

/* sv/masked_table_select_top.sv */
// Top level of the masked table select block.
// A write beat stores one flag word. A random query walks the table once,
// one entry per cycle through the table's single read port, recording
// matches, then scales the draw by the match count and reads the chosen
// match back. A next query first reduces the start index plus one modulo
// the count in 7 shift-subtract steps, then walks from there and stops at
// the first match. The table keeps a valid bit per entry, so it reads as
// zero right after reset with no clearing pass. A finished result waits in
// an output register while the next beat is taken.
module masked_table_select_top #(
	parameter int MAX_ENTRIES = 64,
	parameter int ROLE_BITS   = 8
) (
	input  logic                        clk,
	input  logic                        arst_n,
	mts_in_if.sink                      in_ch,
	mts_out_if.source                   out_ch,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [mts_pkg::APB_AW-1:0]  paddr,
	input  logic [mts_pkg::APB_DW-1:0]  pwdata,
	output logic [mts_pkg::APB_DW-1:0]  prdata,
	output logic                        pready
);

	localparam int AW = $clog2(MAX_ENTRIES);

	logic [mts_pkg::CNT_W-1:0]  entry_count;
	logic                       wr_en;
	logic [AW-1:0]              wr_addr;
	logic [mts_pkg::FLAG_W-1:0] wr_data;
	logic [AW-1:0]              rd_addr;
	logic [mts_pkg::FLAG_W-1:0] rd_data;

	// Register port
	mts_cfg u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.entry_count (entry_count)
	);

	// Flag storage
	mts_table #(
		.MAX_ENTRIES (MAX_ENTRIES)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Search sequencer
	mts_seq #(
		.MAX_ENTRIES (MAX_ENTRIES),
		.ROLE_BITS   (ROLE_BITS)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_ch       (in_ch),
		.out_ch      (out_ch),
		.entry_count (entry_count),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.wr_data     (wr_data),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data)
	);

endmodule

/* tb/sv/mts_pick_checker.sv */
// Checker for masked_table_select_top: mirrors the flag table and compares every result beat.
`timescale 1ns / 1ps

module mts_pick_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	mts_in_if                           in_mon,
	mts_out_if                          out_mon,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic                        pready,
	input  logic [mts_pkg::APB_AW-1:0]  paddr,
	input  logic [mts_pkg::APB_DW-1:0]  pwdata,
	output int                          pending,
	output int                          failures
);

	localparam int TABLE_DEPTH = 64;
	localparam int ROLE_BITS   = 8;
	localparam int PRINT_LIMIT = 40;
	localparam logic [mts_pkg::APB_AW-1:0] COUNT_ADDR =
		mts_pkg::APB_AW'(4 * int'(mts_pkg::REG_ENTRY_COUNT));

	typedef struct packed {
		logic [mts_pkg::IDX_W-1:0] chosen;
		logic                      found;
	} pick_t;

	// Shadow of the block's state
	logic [mts_pkg::FLAG_W-1:0] flag_copy [TABLE_DEPTH];
	logic [mts_pkg::CNT_W-1:0]  count_copy;

	// Selections still owed by the block, oldest first
	pick_t picks_due [$];
	pick_t due;

	initial begin
		for (int i = 0; i < TABLE_DEPTH; i++)
			flag_copy[i] = '0;
		count_copy = mts_pkg::ENTRY_COUNT_RST;
		pending    = 0;
		failures   = 0;
	end

	task automatic report_mismatch(input string what);
		failures++;
		if (failures <= PRINT_LIMIT)
			$display("ERROR %0t: %s", $time, what);
	endtask

	// Expected selection for one query beat, from the shadow table
	function automatic pick_t select_entry(input mts_pkg::mode_t mode,
			input logic [mts_pkg::IDX_W-1:0] start,
			input logic [mts_pkg::ROLE_W-1:0] roles, input logic [mts_pkg::SIDE_W-1:0] side,
			input logic side_given, input logic [mts_pkg::RAND_W-1:0] draw);
		int unsigned span, match_cnt, ordinal, seen, pos;
		logic [mts_pkg::FLAG_W-1:0] need;
		pick_t pick;
		pick = '0;
		span = (count_copy > TABLE_DEPTH) ? TABLE_DEPTH : count_copy;
		need = mts_pkg::FLAG_W'(roles);
		if (side_given)
			need[ROLE_BITS + side] = 1'b1;
		if (mode == mts_pkg::MODE_RANDOM) begin
			match_cnt = 0;
			for (int i = 0; i < span; i++)
				if ((flag_copy[i] & need) == need)
					match_cnt++;
			if (match_cnt > 0) begin
				// Q0.16 draw scaled by the match count, truncated
				ordinal = (32'(draw) * match_cnt) >> 16;
				seen = 0;
				for (int i = 0; i < span; i++) begin
					if ((flag_copy[i] & need) == need) begin
						if (seen == ordinal) begin
							pick.chosen = mts_pkg::IDX_W'(i);
							pick.found  = 1'b1;
							break;
						end
						seen++;
					end
				end
			end
		end else if (span > 0) begin
			// forward walk with wrap, starting after the given entry
			pos = (32'(start) + 1) % span;
			for (int i = 0; i < span; i++) begin
				if ((flag_copy[pos] & need) == need) begin
					pick.chosen = mts_pkg::IDX_W'(pos);
					pick.found  = 1'b1;
					break;
				end
				pos = (pos + 1 == span) ? 0 : pos + 1;
			end
		end
		return pick;
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			// register writes
			if (psel && penable && pwrite && pready && paddr == COUNT_ADDR)
				count_copy = pwdata[mts_pkg::CNT_W-1:0];

			// result beats against the oldest expectation
			if (out_mon.valid && out_mon.ready) begin
				if (picks_due.size() == 0) begin
					report_mismatch($sformatf("result beat entry %0d found %0b with no query waiting",
						out_mon.chosen_entry, out_mon.found));
				end else begin
					due = picks_due.pop_front();
					if (out_mon.chosen_entry !== due.chosen)
						report_mismatch($sformatf("chosen_entry %0d, expected %0d",
							out_mon.chosen_entry, due.chosen));
					if (out_mon.found !== due.found)
						report_mismatch($sformatf("found %0b, expected %0b (entry %0d)",
							out_mon.found, due.found, due.chosen));
				end
			end

			// input beats update the shadow or queue a selection
			if (in_mon.valid && in_mon.ready) begin
				case (mts_pkg::mode_t'(in_mon.mode))
					mts_pkg::MODE_WRITE: begin
						flag_copy[in_mon.entry_index] = in_mon.entry_flags;
					end
					mts_pkg::MODE_RANDOM, mts_pkg::MODE_NEXT: begin
						picks_due.push_back(select_entry(mts_pkg::mode_t'(in_mon.mode),
							in_mon.entry_index, in_mon.role_mask, in_mon.side,
							in_mon.side_given, in_mon.random_word));
					end
					default: ;
				endcase
			end
			pending = picks_due.size();
		end
	end

endmodule

/* tb/sv/tb_masked_table_select_top.sv */
// Testbench top for masked_table_select_top: stimulus, register phases, watchdog and verdict.
`timescale 1ns / 1ps

module tb_masked_table_select_top;

	localparam int IDLE_PCT     = 6;
	localparam int DRAIN_CYCLES = 100;
	localparam int HOLD_CYCLES  = 500;
	localparam int QUIET_LIMIT  = 4000;
	localparam int PHASE_BEATS  = 212;
	localparam int FILL_BEATS   = 24;
	localparam int PHASES       = 8;
	localparam logic [mts_pkg::APB_AW-1:0] COUNT_ADDR =
		mts_pkg::APB_AW'(4 * int'(mts_pkg::REG_ENTRY_COUNT));

	typedef struct {
		mts_pkg::mode_t             mode;
		logic [mts_pkg::IDX_W-1:0]  entry_index;
		logic [mts_pkg::FLAG_W-1:0] entry_flags;
		logic [mts_pkg::ROLE_W-1:0] role_mask;
		logic [mts_pkg::SIDE_W-1:0] side;
		logic                       side_given;
		logic [mts_pkg::RAND_W-1:0] random_word;
	} query_beat_t;

	logic clk = 1'b0;
	logic arst_n;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [mts_pkg::APB_AW-1:0] paddr;
	logic [mts_pkg::APB_DW-1:0] pwdata;
	logic [mts_pkg::APB_DW-1:0] prdata;
	logic                       pready;

	int pending_picks;
	int mismatch_count;
	int quiet_cycles = 0;
	int unsigned count_now = mts_pkg::ENTRY_COUNT_RST;
	bit calm = 1'b0;

	mts_in_if  in_ch ();
	mts_out_if out_ch ();

	masked_table_select_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	mts_pick_checker checker_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_mon   (in_ch),
		.out_mon  (out_ch),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.pready   (pready),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.pending  (pending_picks),
		.failures (mismatch_count)
	);

	always #6 clk = ~clk;

	// Watchdog: too long without any beat on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == QUIET_LIMIT) begin
			$display("tb_masked_table_select_top failed");
			$finish;
		end
	end

	function automatic query_beat_t beat(input mts_pkg::mode_t mode, input int unsigned idx,
			input int unsigned flags, input int unsigned roles, input int unsigned side,
			input bit side_given, input int unsigned draw);
		query_beat_t b;
		b.mode        = mode;
		b.entry_index = mts_pkg::IDX_W'(idx);
		b.entry_flags = mts_pkg::FLAG_W'(flags);
		b.role_mask   = mts_pkg::ROLE_W'(roles);
		b.side        = mts_pkg::SIDE_W'(side);
		b.side_given  = side_given;
		b.random_word = mts_pkg::RAND_W'(draw);
		return b;
	endfunction

	// Random beat: writes mostly inside the searched span, dense flag words,
	// role masks with few bits so that queries find matches
	function automatic query_beat_t random_beat(input bit fill);
		query_beat_t b;
		int unsigned span, pick;
		span = (count_now > 64) ? 64 : count_now;
		b.entry_index = mts_pkg::IDX_W'($urandom);
		b.role_mask   = mts_pkg::ROLE_W'($urandom);
		b.side        = mts_pkg::SIDE_W'($urandom);
		b.side_given  = ($urandom_range(0, 99) < 80);
		b.random_word = mts_pkg::RAND_W'($urandom);
		pick = $urandom_range(0, 99);
		if (fill || pick < 40)
			b.mode = mts_pkg::MODE_WRITE;
		else if (pick < 68)
			b.mode = mts_pkg::MODE_RANDOM;
		else if (pick < 95)
			b.mode = mts_pkg::MODE_NEXT;
		else
			b.mode = mts_pkg::MODE_NOP;
		if (span > 0 && $urandom_range(0, 9) < 8)
			b.entry_index = mts_pkg::IDX_W'($urandom_range(0, span - 1));
		case ($urandom_range(0, 3))
			0, 1: b.entry_flags = mts_pkg::FLAG_W'($urandom | $urandom);
			2: b.entry_flags = mts_pkg::FLAG_W'($urandom);
			default: b.entry_flags = mts_pkg::FLAG_W'($urandom & $urandom);
		endcase
		case ($urandom_range(0, 9))
			0, 1, 2, 3: b.role_mask = mts_pkg::ROLE_W'(1)
				<< $urandom_range(0, mts_pkg::ROLE_W - 1);
			4, 5, 6: b.role_mask = (mts_pkg::ROLE_W'(1) << $urandom_range(0, mts_pkg::ROLE_W - 1))
				| (mts_pkg::ROLE_W'(1) << $urandom_range(0, mts_pkg::ROLE_W - 1));
			7: b.role_mask = '0;
			8: b.role_mask = '1;
			default: ;
		endcase
		return b;
	endfunction

	// One input beat; returns at the edge where it is taken
	task automatic send_beat(input query_beat_t b);
		while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.mode        <= b.mode;
		in_ch.entry_index <= b.entry_index;
		in_ch.entry_flags <= b.entry_flags;
		in_ch.role_mask   <= b.role_mask;
		in_ch.side        <= b.side;
		in_ch.side_given  <= b.side_given;
		in_ch.random_word <= b.random_word;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
	endtask

	// Register write once the block has drained; the extra edge lets the
	// checker count a query taken at the edge just passed
	task automatic write_entry_count(input int unsigned value);
		@(posedge clk);
		wait (pending_picks == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= COUNT_ADDR;
		pwdata  <= mts_pkg::APB_DW'(value & ((1 << mts_pkg::CNT_W) - 1));
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		count_now = value;
	endtask

	// Result ready: sparse random stalls, plus long hold-offs that back the block up
	initial begin : result_ready
		int delivered;
		int next_hold;
		delivered = 0;
		next_hold = 200;
		out_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready)
				delivered++;
			if (delivered >= next_hold) begin
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				next_hold += 700;
				out_ch.ready <= 1'b1;
			end else begin
				out_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
			end
		end
	end

	initial begin : stimulus
		int unsigned counts [PHASES];
		counts = '{64, 1, 0, 127, 2, 45, 64, 14};
		arst_n            = 1'b0;
		in_ch.valid       = 1'b0;
		in_ch.mode        = mts_pkg::MODE_WRITE;
		in_ch.entry_index = '0;
		in_ch.entry_flags = '0;
		in_ch.role_mask   = '0;
		in_ch.side        = '0;
		in_ch.side_given  = 1'b0;
		in_ch.random_word = '0;
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = '0;
		pwdata  = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset entry count
		// table still clear: zero mask matches everything, any real mask finds nothing
		send_beat(beat(mts_pkg::MODE_RANDOM, 0, 0, 'h00, 0, 0, 'h0000));
		send_beat(beat(mts_pkg::MODE_RANDOM, 0, 0, 'h00, 0, 0, 'hFFFF));
		send_beat(beat(mts_pkg::MODE_NEXT, 0, 0, 'h01, 0, 1, 0));
		send_beat(beat(mts_pkg::MODE_WRITE, 0, 'hFFFF, 0, 0, 0, 0));
		send_beat(beat(mts_pkg::MODE_WRITE, 5, 'h0103, 0, 0, 0, 0));
		send_beat(beat(mts_pkg::MODE_WRITE, 13, 'h8081, 0, 0, 0, 0));
		// stored but beyond the searched span
		send_beat(beat(mts_pkg::MODE_WRITE, 63, 'hFFFF, 0, 0, 0, 0));
		send_beat(beat(mts_pkg::MODE_WRITE, 20, 'h0201, 0, 0, 0, 0));
		send_beat(beat(mts_pkg::MODE_RANDOM, 0, 0, 'h01, 0, 1, 'h0000));
		send_beat(beat(mts_pkg::MODE_RANDOM, 0, 0, 'h01, 0, 1, 'hFFFF));
		send_beat(beat(mts_pkg::MODE_RANDOM, 0, 0, 'hFF, 0, 0, 'h8000));
		send_beat(beat(mts_pkg::MODE_RANDOM, 0, 0, 'h80, 7, 1, 'hFFFF));
		send_beat(beat(mts_pkg::MODE_NEXT, 0, 0, 'h01, 0, 1, 0));
		// wraps back to entry 0
		send_beat(beat(mts_pkg::MODE_NEXT, 5, 0, 'h01, 0, 1, 0));
		// start on the last entry in use
		send_beat(beat(mts_pkg::MODE_NEXT, 13, 0, 'h01, 0, 1, 0));
		// start beyond the count
		send_beat(beat(mts_pkg::MODE_NEXT, 63, 0, 'h01, 7, 1, 0));
		// next mode with unknown side
		send_beat(beat(mts_pkg::MODE_NEXT, 0, 0, 'h02, 0, 0, 0));
		send_beat(beat(mts_pkg::MODE_NOP, 63, 'hFFFF, 'hFF, 7, 1, 'hFFFF));
		send_beat(beat(mts_pkg::MODE_NEXT, 40, 0, 'h00, 0, 0, 0));
		send_beat(beat(mts_pkg::MODE_RANDOM, 0, 0, 'h40, 3, 1, 'h7FFF));
		send_beat(beat(mts_pkg::MODE_WRITE, 0, 'h0000, 0, 0, 0, 0));
		send_beat(beat(mts_pkg::MODE_RANDOM, 0, 0, 'h01, 0, 1, 'h0000));
		in_ch.valid <= 1'b0;

		// Random phases, one entry count each, extremes included
		for (int p = 0; p < PHASES; p++) begin
			write_entry_count(counts[p]);
			for (int n = 0; n < PHASE_BEATS; n++) begin
				calm = (p == 5) && (n < 180);
				send_beat(random_beat(n < FILL_BEATS));
			end
			in_ch.valid <= 1'b0;
		end
		calm = 1'b0;

		@(posedge clk);
		wait (pending_picks == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pending_picks == 0)
			$display("tb_masked_table_select_top passed");
		else
			$display("tb_masked_table_select_top failed");
		$finish;
	end

endmodule

/* filelist.f */
sv/mts_pkg.sv
sv/mts_in_if.sv
sv/mts_out_if.sv
sv/mts_cfg.sv
sv/mts_table.sv
sv/mts_seq.sv
sv/masked_table_select_top.sv
tb/sv/mts_pick_checker.sv
tb/sv/tb_masked_table_select_top.sv
